>>> sv/retransmit_packet_store_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef RETRANSMIT_PACKET_STORE_UNIT_DEFINES_SVH
`define RETRANSMIT_PACKET_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RPS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rps check failed");

// Next-cycle implication, disabled during reset.
`define RPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rps check failed");

`endif

>>> sv/rps_pkg.sv
package rps_pkg;

   localparam int MAX_RESULTS = 64;
   localparam int KCNT_W      = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_TICK       = 2'd1,
      OP_RETRANSMIT = 2'd2,
      OP_UNUSED     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_LEN  = 2'd1,
      ST_RING_FULL = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic {
      CSR_THRESHOLD = 1'b0,
      CSR_TIMEOUT   = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SORT_START,
      S_SORT_RD,
      S_SORT_EV,
      S_SORT_WR,
      S_RT_RD,
      S_RT_EV,
      S_RT_END
   } state_type;

   typedef struct packed {
      logic [23:0] psn;
      logic [31:0] tag;
      logic [12:0] len;
   } pkt_type;

   typedef struct packed {
      logic    valid;
      pkt_type pkt;
   } slot_type;

   typedef struct packed {
      logic       kind;
      status_type status;
      logic       flushed;
      pkt_type    pkt;
      logic       last;
   } rsp_type;

endpackage

>>> sv/rps_ram.sv
module rps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/retransmit_packet_store_unit.sv
// Channel   Direction  Handshake             Contents
// req_      in         valid / stall         operation, psn, tag, length, expected psn
// rsp_      out        valid / stall         status or packet descriptor, last marker
// csr_      in         valid / ready         register index and data
//
// Insert and unknown operations and a tick without flush are answered from idle;
// a flush of the batch entries runs a selection sort
// that rescans the batch memory once for every slot it writes to the store.
// A retransmit reads every used store slot through the store memory read port and can be
// held by a stall on the result side. Reset is synchronous and needs no clearing pass.
// Requests are not taken while an operation runs or while an output waits under stall.
module retransmit_packet_store_unit #(
   parameter int BATCH_DEPTH = 16,
   parameter int STORE_DEPTH = 64,
   parameter int MAX_LENGTH  = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [23:0] req_psn,
   input  logic [31:0] req_payload_tag,
   input  logic [12:0] req_length,
   input  logic [23:0] req_expected_psn,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic        rsp_flushed,
   output logic [23:0] rsp_out_psn,
   output logic [31:0] rsp_out_tag,
   output logic [12:0] rsp_out_length,
   output logic [23:0] rsp_lowest_seen,
   output logic [23:0] rsp_highest_seen,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int BW  = $clog2(BATCH_DEPTH);
   localparam int BCW = $clog2(BATCH_DEPTH + 1);
   localparam int SW  = $clog2(STORE_DEPTH);
   localparam int SCW = $clog2(STORE_DEPTH + 1);
   localparam int PW  = $bits(rps_pkg::pkt_type);
   localparam int LW  = $bits(rps_pkg::slot_type);

   rps_pkg::state_type state_ff, state_in;
   logic [4:0]  threshold_ff, threshold_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [BW-1:0]  head_ff, head_in, tail_ff, tail_in, pos_ff, pos_in, best_idx_ff, best_idx_in;
   logic [BCW-1:0] fill_ff, fill_in, scan_ff, scan_in, rank_ff, rank_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [SCW-1:0] used_ff, used_in, idx_ff, idx_in;
   logic [23:0] lowest_ff, lowest_in, highest_ff, highest_in, exp_ff, exp_in;
   logic [BATCH_DEPTH-1:0] taken_ff, taken_in;
   rps_pkg::pkt_type best_ff, best_in, pend_ff, pend_in;
   logic best_v_ff, best_v_in, pend_v_ff, pend_v_in;
   logic [rps_pkg::KCNT_W-1:0] k_ff, k_in;
   rps_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic          b_wr_en, b_rd_en;
   logic [BW-1:0] b_wr_addr, b_rd_addr;
   logic [PW-1:0] b_wr_data, b_rd_data;
   logic          s_wr_en, s_rd_en;
   logic [SW-1:0] s_wr_addr, s_rd_addr;
   logic [LW-1:0] s_wr_data, s_rd_data;

   rps_pkg::pkt_type  b_pkt;
   rps_pkg::slot_type s_slot;
   logic out_free, accept, len_bad, do_flush;
   logic [15:0] elapsed_inc;

   rps_ram #(.WIDTH(PW), .DEPTH(BATCH_DEPTH)) u_batch (
      .clock(clock), .wr_en(b_wr_en), .wr_addr(b_wr_addr), .wr_data(b_wr_data),
      .rd_en(b_rd_en), .rd_addr(b_rd_addr), .rd_data(b_rd_data)
   );

   rps_ram #(.WIDTH(LW), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .wr_en(s_wr_en), .wr_addr(s_wr_addr), .wr_data(s_wr_data),
      .rd_en(s_rd_en), .rd_addr(s_rd_addr), .rd_data(s_rd_data)
   );

   function automatic logic [BW-1:0] ring_next(input logic [BW-1:0] p);
      ring_next = (p == BW'(BATCH_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign b_pkt     = rps_pkg::pkt_type'(b_rd_data);
   assign s_slot    = rps_pkg::slot_type'(s_rd_data);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != rps_pkg::S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign len_bad   = (req_length == 13'd0) || (req_length > 13'(MAX_LENGTH));
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign do_flush  = (fill_ff != '0) &&
                      ((32'(fill_ff) >= 32'(threshold_ff)) || (elapsed_inc >= timeout_ff));

   always_comb begin
      state_in     = state_ff;
      threshold_in = threshold_ff;
      timeout_in   = timeout_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      elapsed_in   = elapsed_ff;
      used_in      = used_ff;
      lowest_in    = lowest_ff;
      highest_in   = highest_ff;
      exp_in       = exp_ff;
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      rank_in      = rank_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      best_v_in    = best_v_ff;
      taken_in     = taken_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      b_wr_en   = 1'b0;
      b_wr_addr = tail_ff;
      b_wr_data = PW'({req_psn, req_payload_tag, req_length});
      b_rd_en   = 1'b0;
      b_rd_addr = pos_ff;
      s_wr_en   = 1'b0;
      s_wr_addr = used_ff[SW-1:0];
      s_wr_data = LW'({1'b1, best_ff});
      s_rd_en   = 1'b0;
      s_rd_addr = idx_ff[SW-1:0];

      if (csr_valid) begin
         case (csr_index)
            2'(rps_pkg::CSR_THRESHOLD): threshold_in = csr_data[4:0];
            2'(rps_pkg::CSR_TIMEOUT):   timeout_in   = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         rps_pkg::S_IDLE: begin
            if (accept) begin
               rsp_in = '0;
               rsp_in.last = 1'b1;
               case (rps_pkg::op_type'(req_operation))
                  rps_pkg::OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (len_bad) begin
                        rsp_in.status = rps_pkg::ST_BAD_LEN;
                     end else if (32'(fill_ff) >= BATCH_DEPTH) begin
                        rsp_in.status = rps_pkg::ST_RING_FULL;
                     end else begin
                        b_wr_en = 1'b1;
                        tail_in = ring_next(tail_ff);
                        fill_in = fill_ff + 1'b1;
                        if (req_psn < lowest_ff || lowest_ff == 24'd0) begin
                           lowest_in = req_psn;
                        end
                        if (req_psn > highest_ff) begin
                           highest_in = req_psn;
                        end
                     end
                  end
                  rps_pkg::OP_TICK: begin
                     elapsed_in = elapsed_inc;
                     if (!do_flush) begin
                        rsp_valid_in = 1'b1;
                     end else if (32'(used_ff) + 32'(fill_ff) > STORE_DEPTH) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = rps_pkg::ST_OVERFLOW;
                     end else begin
                        taken_in = '0;
                        rank_in  = '0;
                        state_in = rps_pkg::S_SORT_START;
                     end
                  end
                  rps_pkg::OP_RETRANSMIT: begin
                     if (used_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        exp_in    = req_expected_psn;
                        idx_in    = '0;
                        k_in      = '0;
                        pend_v_in = 1'b0;
                        state_in  = rps_pkg::S_RT_RD;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end

         // Selection sort: each pass picks the smallest untaken PSN, earliest on ties.
         rps_pkg::S_SORT_START: begin
            pos_in    = head_ff;
            scan_in   = '0;
            best_v_in = 1'b0;
            state_in  = rps_pkg::S_SORT_RD;
         end
         rps_pkg::S_SORT_RD: begin
            b_rd_en  = 1'b1;
            state_in = rps_pkg::S_SORT_EV;
         end
         rps_pkg::S_SORT_EV: begin
            if (!taken_ff[pos_ff] && (!best_v_ff || b_pkt.psn < best_ff.psn)) begin
               best_v_in   = 1'b1;
               best_in     = b_pkt;
               best_idx_in = pos_ff;
            end
            pos_in  = ring_next(pos_ff);
            scan_in = scan_ff + 1'b1;
            state_in = (scan_ff == fill_ff - 1'b1) ? rps_pkg::S_SORT_WR : rps_pkg::S_SORT_RD;
         end
         rps_pkg::S_SORT_WR: begin
            s_wr_en = 1'b1;
            taken_in[best_idx_ff] = 1'b1;
            used_in = used_ff + 1'b1;
            rank_in = rank_ff + 1'b1;
            if (rank_ff == fill_ff - 1'b1) begin
               head_in      = tail_ff;
               fill_in      = '0;
               elapsed_in   = '0;
               rsp_in       = '0;
               rsp_in.flushed = 1'b1;
               rsp_in.last  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rps_pkg::S_IDLE;
            end else begin
               state_in = rps_pkg::S_SORT_START;
            end
         end

         // A matching descriptor is held back until the next one is found so the final one can carry last.
         rps_pkg::S_RT_RD: begin
            s_rd_en  = 1'b1;
            state_in = rps_pkg::S_RT_EV;
         end
         rps_pkg::S_RT_EV: begin
            if (s_slot.valid && s_slot.pkt.psn >= exp_ff &&
                32'(k_ff) < rps_pkg::MAX_RESULTS) begin
               if (!pend_v_ff || out_free) begin
                  if (pend_v_ff) begin
                     rsp_in       = '0;
                     rsp_in.kind  = 1'b1;
                     rsp_in.pkt   = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in   = s_slot.pkt;
                  pend_v_in = 1'b1;
                  k_in      = k_ff + 1'b1;
                  idx_in    = idx_ff + 1'b1;
                  state_in  = (idx_ff + 1'b1 == used_ff) ? rps_pkg::S_RT_END
                                                         : rps_pkg::S_RT_RD;
               end
            end else begin
               if (s_slot.valid && s_slot.pkt.psn < exp_ff) begin
                  s_wr_en   = 1'b1;
                  s_wr_addr = idx_ff[SW-1:0];
                  s_wr_data = LW'({1'b0, s_slot.pkt});
               end
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == used_ff) ? rps_pkg::S_RT_END : rps_pkg::S_RT_RD;
            end
         end
         rps_pkg::S_RT_END: begin
            if (out_free) begin
               rsp_in       = '0;
               rsp_in.last  = 1'b1;
               rsp_in.kind  = pend_v_ff;
               rsp_in.pkt   = pend_v_ff ? pend_ff : '0;
               rsp_valid_in = 1'b1;
               state_in     = rps_pkg::S_IDLE;
            end
         end
         default: state_in = rps_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rps_pkg::S_IDLE;
         threshold_ff <= 5'd8;
         timeout_ff   <= 16'd10;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         elapsed_ff   <= '0;
         used_ff      <= '0;
         lowest_ff    <= '0;
         highest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         best_v_ff    <= 1'b0;
         pend_v_ff    <= 1'b0;
         taken_ff     <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         timeout_ff   <= timeout_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         elapsed_ff   <= elapsed_in;
         used_ff      <= used_in;
         lowest_ff    <= lowest_in;
         highest_ff   <= highest_in;
         rsp_valid_ff <= rsp_valid_in;
         best_v_ff    <= best_v_in;
         pend_v_ff    <= pend_v_in;
         taken_ff     <= taken_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff      <= exp_in;
      pos_ff      <= pos_in;
      scan_ff     <= scan_in;
      rank_ff     <= rank_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      idx_ff      <= idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   // The seen PSNs change only on inserts, which never overlap a pending result.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_status       = rsp_ff.status;
   assign rsp_flushed      = rsp_ff.flushed;
   assign rsp_out_psn      = rsp_ff.pkt.psn;
   assign rsp_out_tag      = rsp_ff.pkt.tag;
   assign rsp_out_length   = rsp_ff.pkt.len;
   assign rsp_lowest_seen  = lowest_ff;
   assign rsp_highest_seen = highest_ff;
   assign rsp_last         = rsp_ff.last;

endmodule

>>> sv/rps_checker.sv
`include "retransmit_packet_store_unit_defines.svh"

module rps_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_kind,
   input logic [1:0] rsp_status,
   input logic       rsp_flushed,
   input logic       rsp_last
);

   `RPS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `RPS_ASSERT_NOW(a_desc_ok, clock, reset, rsp_valid && rsp_kind, rsp_status == 2'd0)
   `RPS_ASSERT_NOW(a_status_last, clock, reset, rsp_valid && !rsp_kind, rsp_last)
   `RPS_ASSERT_NOW(a_flush_ok, clock, reset, rsp_valid && rsp_flushed,
                   !rsp_kind && rsp_status == 2'd0)

endmodule

bind retransmit_packet_store_unit rps_checker u_rps_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_kind(rsp_kind), .rsp_status(rsp_status), .rsp_flushed(rsp_flushed),
   .rsp_last(rsp_last)
);
